>>> design/mmul_pkg.sv
// ----------------------------------------------------------------------------
// mmul_pkg
// Shared types, constants and helpers for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mmul_pkg;

    // Largest matrix side held in the element stores.
    localparam int MAX_DIM = 8;
    // Largest usable side; row and column fields are three bits wide.
    localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    // Field and storage widths.
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int VAL_W     = 32;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM_CAP) + 1;
    localparam int FRAC_W    = 16;
    localparam int SHIFT_W   = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = 2 * IDX_W + VAL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_USER_W   = 2;
    localparam int M_FIELDS_W = 2 * IDX_W + VAL_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Input operation codes carried on tuser.
    typedef enum logic [S_USER_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              first_k;
        logic              last_k;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last_elem;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic loaded;
    } stat_t;

    // Clamp a dimension register to the usable range.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > DIM_W'(DIM_CAP)) begin
            d = DIM_W'(DIM_CAP);
        end else begin
            d = v;
        end
        return d;
    endfunction

    // Store address of an element.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_DIM + int'(col));
    endfunction

endpackage

>>> design/mmul_ctrl.sv
// ----------------------------------------------------------------------------
// mmul_ctrl
// Holds the dimension registers, decodes input beats and sequences the
// row, column and inner-product loops of a compute request.
// ----------------------------------------------------------------------------
module mmul_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [mmul_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [mmul_pkg::DIM_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmul_pkg::S_USER_W-1:0]       s_op,
    input  logic [mmul_pkg::IDX_W-1:0]          s_row,
    input  logic [mmul_pkg::IDX_W-1:0]          s_col,
    output mmul_pkg::cmd_t                      cmd,
    input  mmul_pkg::stat_t                     stat
);
    import mmul_pkg::*;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  c_reg, c_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [DIM_W-1:0]  m_dim, k_dim, n_dim;
    logic              accept;
    logic              k_last, c_last, r_last;
    logic              row_in_a, col_in_a, row_in_b, col_in_b;

    // Effective dimensions and loop end flags.
    assign m_dim  = eff_dim(rows_reg);
    assign k_dim  = eff_dim(inner_reg);
    assign n_dim  = eff_dim(cols_reg);
    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == k_dim;
    assign c_last = (DIM_W'(c_reg) + DIM_W'(1)) == n_dim;
    assign r_last = (DIM_W'(r_reg) + DIM_W'(1)) == m_dim;

    // Range checks for load beats.
    assign row_in_a = DIM_W'(s_row) < m_dim;
    assign col_in_a = DIM_W'(s_col) < k_dim;
    assign row_in_b = DIM_W'(s_row) < k_dim;
    assign col_in_b = DIM_W'(s_col) < n_dim;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Dimension registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(3);
            inner_reg <= DIM_W'(3);
            cols_reg  <= DIM_W'(3);
        end else if (cfg_wen) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_ROWS_A:    rows_reg  <= cfg_wdata;
                CFG_INNER_DIM: inner_reg <= cfg_wdata;
                CFG_COLS_B:    cols_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // State and loop counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (op_t'(s_op) == OP_COMPUTE)) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (stat.loaded) begin
                    state_next = (r_last && c_last) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Loop counters: inner index steps while issuing, row and column step
    // once an element has been handed to the output register.
    always_comb begin
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        case (state_reg)
            ST_IDLE: begin
                r_next = '0;
                c_next = '0;
                k_next = '0;
            end
            ST_ISSUE: begin
                k_next = k_last ? '0 : k_reg + IDX_W'(1);
            end
            ST_WAIT: begin
                if (stat.loaded) begin
                    if (c_last) begin
                        c_next = '0;
                        r_next = r_reg + IDX_W'(1);
                    end else begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                r_next = '0;
                c_next = '0;
                k_next = '0;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd           = '0;
        cmd.wr_addr   = addr_of(s_row, s_col);
        cmd.rd_addr_a = addr_of(r_reg, k_reg);
        cmd.rd_addr_b = addr_of(k_reg, c_reg);
        cmd.first_k   = (k_reg == '0);
        cmd.last_k    = k_last;
        cmd.row       = r_reg;
        cmd.col       = c_reg;
        cmd.last_elem = r_last && c_last;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op_t'(s_op))
                        OP_LOAD_A: cmd.wr_a = row_in_a && col_in_a;
                        OP_LOAD_B: cmd.wr_b = row_in_b && col_in_b;
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: cmd.rd_en = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

>>> design/mmul_dp.sv
// ----------------------------------------------------------------------------
// mmul_dp
// Element stores, multiply-accumulate pipeline, floor shift with saturation
// and the result register of the output stream.
// ----------------------------------------------------------------------------
module mmul_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mmul_pkg::VAL_W-1:0]          s_value,
    input  mmul_pkg::cmd_t                      cmd,
    output mmul_pkg::stat_t                     stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmul_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import mmul_pkg::*;

    logic [VAL_W-1:0]          mem_a [DEPTH];
    logic [VAL_W-1:0]          mem_b [DEPTH];
    logic [VAL_W-1:0]          a_reg, b_reg;
    logic                      v1_reg, f1_reg, l1_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      v2_reg, f2_reg, l2_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      pend_reg;
    logic                      loaded;
    logic signed [SHIFT_W-1:0] shifted;
    logic                      fits;
    logic [VAL_W-1:0]          sat_val;
    logic                      out_valid_reg;
    logic [M_DATA_W-1:0]       out_data_reg;
    logic                      out_ovf_reg, out_last_reg;

    // Store A: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[cmd.wr_addr] <= s_value;
        end
        if (cmd.rd_en) begin
            a_reg <= mem_a[cmd.rd_addr_a];
        end
    end

    // Store B: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            mem_b[cmd.wr_addr] <= s_value;
        end
        if (cmd.rd_en) begin
            b_reg <= mem_b[cmd.rd_addr_b];
        end
    end

    // Pipeline control: read, multiply, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
        f1_reg <= cmd.first_k;
        l1_reg <= cmd.last_k;
        f2_reg <= f1_reg;
        l2_reg <= l1_reg;
    end

    // Signed multiply of the two operands.
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= $signed(a_reg) * $signed(b_reg);
        end
    end

    // Exact accumulation; the first product of an element restarts the sum.
    always_comb begin
        if (f2_reg) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
    end

    // A finished sum waits here until the output register is free.
    assign loaded      = pend_reg && (!out_valid_reg || m_tready);
    assign stat.loaded = loaded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (v2_reg && l2_reg) begin
            pend_reg <= 1'b1;
        end else if (loaded) begin
            pend_reg <= 1'b0;
        end
    end

    // Floor shift of the fraction, then saturation to 32 bits.
    assign shifted = SHIFT_W'(acc_reg >>> FRAC_W);
    assign fits    = (shifted[SHIFT_W-1:VAL_W-1] == '0) ||
                     (shifted[SHIFT_W-1:VAL_W-1] == '1);

    always_comb begin
        if (fits) begin
            sat_val = shifted[VAL_W-1:0];
        end else if (shifted[SHIFT_W-1]) begin
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (loaded) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (loaded) begin
            out_data_reg <= M_DATA_W'({sat_val, cmd.col, cmd.row});
            out_ovf_reg  <= !fits;
            out_last_reg <= cmd.last_elem;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> design/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Q16.16 matrix product C = A * B with loadable element stores.
//
//   Channel   Direction  Carries
//   s_        in         load A, load B or compute request (op on tuser)
//   m_        out        one product element per beat, last on tlast
//   cfg_      in         rows_a, inner_dim, cols_b dimension registers
//
// For a compute beat one shared multiplier-accumulator works through the
// K inner products of each element, one operand pair per cycle. Reset
// is synchronous and active low; it clears control state and sets the
// dimensions to three. The element stores are not cleared. A stalled output
// holds the next finished element in the accumulator and pauses the sequence.
// ----------------------------------------------------------------------------
module matrix_multiply (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wen,
    input  logic [mmul_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [mmul_pkg::DIM_W-1:0]          cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmul_pkg::S_DATA_W-1:0]       s_tdata,  // row, col, value
    input  logic [mmul_pkg::S_USER_W-1:0]       s_tuser,  // op
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmul_pkg::M_DATA_W-1:0]       m_tdata,  // out_row, out_col, product
    output logic                                m_tuser,  // overflow
    output logic                                m_tlast
);
    import mmul_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [IDX_W-1:0]  s_row, s_col;
    logic [VAL_W-1:0]  s_value;

    // Unpack the input beat.
    assign s_row   = s_tdata[IDX_W-1:0];
    assign s_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign s_value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    mmul_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .s_row     (s_row),
        .s_col     (s_col),
        .cmd       (cmd),
        .stat      (stat)
    );

    mmul_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_value   (s_value),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
